// File: hdl/essp_pkg.sv
// Shared types and constants for the entity slot property store.
`default_nettype none
package essp_pkg;
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_SETF  = 3'd4;
    localparam logic [2:0] OP_CHKF  = 3'd5;
    localparam logic [2:0] OP_CSUM  = 3'd6;
    localparam logic [2:0] OP_CLRD  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;

    localparam int ROT_TOP = 31;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] entity;
        logic [15:0] property_req;
        logic [31:0] value;
        logic [31:0] frame;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entity_id;
        logic [31:0] read_value;
        logic        frame_ok;
        logic [31:0] checksum;
        logic [16:0] live_count;
    } rsp_t;
endpackage
`default_nettype wire

// File: hdl/essp_cmd_fifo.sv
// Two-entry command queue between the input side and the execution engine.
`default_nettype none
module essp_cmd_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire essp_pkg::cmd_t  in_cmd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output essp_pkg::cmd_t       out_cmd
);
    essp_pkg::cmd_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= in_cmd;
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overrun");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (wptr_reg == rptr_reg)) else $error("ptr mismatch on empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (wptr_reg == rptr_reg)) else $error("ptr mismatch on full");
endmodule
`default_nettype wire

// File: hdl/essp_engine.sv
// Execution engine: slot state, property memory, free stack and sweeps.
`default_nettype none
module essp_engine #(
    parameter int MAX_SLOTS = 1024,
    parameter int MAX_PROPS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire essp_pkg::cmd_t  cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output essp_pkg::rsp_t       rsp
);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = (MAX_PROPS > 1) ? $clog2(MAX_PROPS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int AW = SW + PW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_SUMR = 3'd4;
    localparam logic [2:0] S_SUMA = 3'd5;
    localparam logic [2:0] S_RSP  = 3'd6;
    localparam logic [2:0] S_DCLR = 3'd7;

    logic [31:0] prop_mem  [MAX_SLOTS*MAX_PROPS];
    logic [31:0] cframe_mem[MAX_SLOTS];
    logic [SW-1:0] stack_mem[MAX_SLOTS];
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] dirty_reg;

    logic [2:0]    state_reg;
    essp_pkg::cmd_t c_reg;
    essp_pkg::rsp_t r_reg;
    logic          rv_reg;
    logic [CW-1:0] depth_reg, fresh_reg, count_reg;
    logic [31:0]   cframe_reg;
    logic [SW-1:0] slot_reg;
    logic [PW-1:0] prop_reg;
    logic          plast_reg;
    logic [31:0]   sum_reg;
    logic [31:0]   pdata_reg, cfdata_reg;
    logic [SW-1:0] popdata_reg;
    logic          pop_reg;

    logic          ent_in, ent_ok, prop_ok;
    logic [SW-1:0] ent_s;
    logic [PW-1:0] prop_p;
    logic [31:0]   sx;
    logic [AW-1:0] raddr;
    essp_pkg::rsp_t r_init, r_clr;

    assign ent_in  = ({16'd0, cmd.entity} < 32'(MAX_SLOTS));
    assign ent_s   = cmd.entity[SW-1:0];
    assign ent_ok  = ent_in && valid_reg[ent_s];
    assign prop_ok = ({16'd0, cmd.property_req} < 32'(MAX_PROPS));
    assign prop_p  = cmd.property_req[PW-1:0];
    assign cmd_ready = (state_reg == S_IDLE) && !rv_reg;
    assign rsp_valid = rv_reg;
    assign rsp = r_reg;
    assign sx = sum_reg ^ pdata_reg;

    always_comb begin
        raddr = {c_reg.entity[SW-1:0], c_reg.property_req[PW-1:0]};
        if (state_reg == S_SUMR || state_reg == S_SUMA) raddr = {slot_reg, prop_reg};
        if (state_reg == S_IDLE) raddr = {ent_s, prop_p};
    end

    // result as known at accept time
    always_comb begin
        r_init = '0;
        r_init.live_count = 17'(count_reg);
        case (cmd.operation)
            essp_pkg::OP_ALLOC: begin
                if (depth_reg == '0 && fresh_reg >= CW'(MAX_SLOTS))
                    r_init.status = essp_pkg::ST_LIMIT;
            end
            essp_pkg::OP_FREE: begin
                if (ent_ok) r_init.live_count = 17'(count_reg - CW'(1));
                else r_init.status = essp_pkg::ST_INVAL;
            end
            essp_pkg::OP_READ, essp_pkg::OP_WRITE: begin
                if (!(ent_ok && prop_ok)) r_init.status = essp_pkg::ST_INVAL;
            end
            essp_pkg::OP_CHKF: begin
                if (!ent_ok) r_init.status = essp_pkg::ST_INVAL;
            end
            default: ;
        endcase
    end

    // result update when an allocated slot goes live
    always_comb begin
        r_clr = r_reg;
        r_clr.entity_id = 16'(slot_reg);
        if (!valid_reg[slot_reg]) r_clr.live_count = 17'(count_reg + CW'(1));
    end

    always_ff @(posedge aclk) begin
        pdata_reg   <= prop_mem[raddr];
        cfdata_reg  <= cframe_mem[ent_s];
        popdata_reg <= stack_mem[depth_reg[SW-1:0] - SW'(1)];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CLR)
            prop_mem[{slot_reg, prop_reg}] <= 32'd0;
        if (state_reg == S_RMW && pdata_reg != c_reg.value)
            prop_mem[{c_reg.entity[SW-1:0], c_reg.property_req[PW-1:0]}] <= c_reg.value;
        if (state_reg == S_IDLE && cmd_valid && cmd_ready && cmd.operation == essp_pkg::OP_FREE
            && ent_ok)
            stack_mem[depth_reg[SW-1:0]] <= ent_s;
        if (state_reg == S_CLR && prop_reg == '0)
            cframe_mem[slot_reg] <= cframe_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            rv_reg     <= 1'b0;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            depth_reg  <= '0;
            fresh_reg  <= '0;
            count_reg  <= '0;
            cframe_reg <= '0;
            pop_reg    <= 1'b0;
        end else begin
            if (rv_reg && rsp_ready) rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        c_reg <= cmd;
                        r_reg <= r_init;
                        case (cmd.operation)
                            essp_pkg::OP_ALLOC: begin
                                if (depth_reg != '0) begin
                                    pop_reg   <= 1'b1;
                                    depth_reg <= depth_reg - CW'(1);
                                    state_reg <= S_RD;
                                end else if (fresh_reg < CW'(MAX_SLOTS)) begin
                                    pop_reg   <= 1'b0;
                                    slot_reg  <= fresh_reg[SW-1:0];
                                    fresh_reg <= fresh_reg + CW'(1);
                                    state_reg <= S_RD;
                                end else begin
                                    rv_reg <= 1'b1;
                                end
                            end
                            essp_pkg::OP_FREE: begin
                                if (ent_ok) begin
                                    valid_reg[ent_s] <= 1'b0;
                                    dirty_reg[ent_s] <= 1'b1;
                                    depth_reg <= depth_reg + CW'(1);
                                    count_reg <= count_reg - CW'(1);
                                end
                                rv_reg <= 1'b1;
                            end
                            essp_pkg::OP_READ, essp_pkg::OP_WRITE: begin
                                if (ent_ok && prop_ok) state_reg <= S_RD;
                                else rv_reg <= 1'b1;
                            end
                            essp_pkg::OP_SETF: begin
                                cframe_reg <= cmd.frame;
                                rv_reg <= 1'b1;
                            end
                            essp_pkg::OP_CHKF: begin
                                if (ent_ok) state_reg <= S_RD;
                                else rv_reg <= 1'b1;
                            end
                            essp_pkg::OP_CSUM: begin
                                sum_reg   <= '0;
                                slot_reg  <= '0;
                                prop_reg  <= '0;
                                state_reg <= S_SUMR;
                            end
                            default: begin
                                dirty_reg <= '0;
                                rv_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    case (c_reg.operation)
                        essp_pkg::OP_ALLOC: begin
                            if (pop_reg) slot_reg <= popdata_reg;
                            prop_reg  <= '0;
                            state_reg <= S_CLR;
                        end
                        essp_pkg::OP_READ: begin
                            r_reg.read_value <= pdata_reg;
                            state_reg <= S_RSP;
                        end
                        essp_pkg::OP_WRITE: state_reg <= S_RMW;
                        default: begin
                            r_reg.frame_ok <= ($signed(cfdata_reg) <= $signed(c_reg.frame));
                            state_reg <= S_RSP;
                        end
                    endcase
                end
                S_RMW: begin
                    if (pdata_reg != c_reg.value) dirty_reg[c_reg.entity[SW-1:0]] <= 1'b1;
                    state_reg <= S_RSP;
                end
                S_CLR: begin
                    if (prop_reg == '0) begin
                        if (!valid_reg[slot_reg]) count_reg <= count_reg + CW'(1);
                        valid_reg[slot_reg] <= 1'b1;
                        dirty_reg[slot_reg] <= 1'b1;
                        r_reg <= r_clr;
                    end
                    if (32'(prop_reg) == MAX_PROPS - 1) state_reg <= S_RSP;
                    else prop_reg <= prop_reg + PW'(1);
                end
                S_SUMR: begin
                    // skip invalid slots; else issue read of (slot,prop)
                    if (!valid_reg[slot_reg]) begin
                        if (32'(slot_reg) == MAX_SLOTS - 1) begin
                            r_reg.checksum <= sum_reg ^ cframe_reg;
                            state_reg <= S_RSP;
                        end else slot_reg <= slot_reg + SW'(1);
                    end else begin
                        plast_reg <= (32'(prop_reg) == MAX_PROPS - 1);
                        state_reg <= S_SUMA;
                    end
                end
                S_SUMA: begin
                    if (plast_reg) begin
                        sum_reg <= {sx[30:0], sx[essp_pkg::ROT_TOP]} ^ 32'(slot_reg);
                        prop_reg <= '0;
                        if (32'(slot_reg) == MAX_SLOTS - 1) begin
                            r_reg.checksum <= {sx[30:0], sx[essp_pkg::ROT_TOP]}
                                ^ 32'(slot_reg) ^ cframe_reg;
                            state_reg <= S_RSP;
                        end else begin
                            slot_reg  <= slot_reg + SW'(1);
                            state_reg <= S_SUMR;
                        end
                    end else begin
                        sum_reg  <= {sx[30:0], sx[essp_pkg::ROT_TOP]};
                        prop_reg <= prop_reg + PW'(1);
                        state_reg <= S_SUMR;
                    end
                end
                S_RSP: begin
                    rv_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        rv_reg |-> (state_reg == S_IDLE)) else $error("result pending while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fresh_reg) else $error("live count above slots handed out");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ((depth_reg + count_reg) == fresh_reg))
        else $error("slot accounting broken");
endmodule
`default_nettype wire

// File: hdl/entity_slot_property_store_top.sv
// Top level of the entity slot property store.
//  channel | dir | tdata fields (low bit up)                              | tuser
//  s_      | in  | operation, entity, property_req, value, frame (99b->104)| -
//  m_      | out | status, entity_id, read_value, frame_ok, checksum,     | -
//          |     | live_count (100b -> 104)                               |
// Read and write go through the property memory port, check frame through the
// frame memory; alloc clears the row one entry a cycle; checksum walks every slot,
// skipping invalid slots and reading each property of a valid slot through the
// single memory read port.
// Reset clears slot valid and dirty flags, stack depth, counters and frame.
// A two-entry queue decouples the input; a held result stalls the engine, and the input once the queue is full.
`default_nettype none
module entity_slot_property_store_top #(
    parameter int MAX_SLOTS = 1024,
    parameter int MAX_PROPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,  // operation,entity,property_req,value,frame
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0] m_tdata   // status,entity_id,read_value,frame_ok,checksum,live_count
);
    essp_pkg::cmd_t in_cmd, q_cmd;
    essp_pkg::rsp_t rsp;
    logic q_valid, q_ready;

    assign in_cmd.operation    = s_tdata[2:0];
    assign in_cmd.entity       = s_tdata[18:3];
    assign in_cmd.property_req = s_tdata[34:19];
    assign in_cmd.value        = s_tdata[66:35];
    assign in_cmd.frame        = s_tdata[98:67];

    essp_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    essp_engine #(.MAX_SLOTS(MAX_SLOTS), .MAX_PROPS(MAX_PROPS)) u_eng (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .rsp_valid(m_tvalid), .rsp_ready(m_tready), .rsp(rsp)
    );

    assign m_tdata = {4'd0, rsp.live_count, rsp.checksum, rsp.frame_ok,
                      rsp.read_value, rsp.entity_id, rsp.status};
endmodule
`default_nettype wire

// File: bench/entity_slot_property_store_top_tb.sv
// Self-checking testbench for the entity slot property store top level.
`default_nettype none
module entity_slot_property_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 1024;
    localparam int PROPS     = 16;
    localparam int WDOG_MAX  = 200000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] entity_id;
        logic [31:0] read_value;
        logic        frame_ok;
        logic [31:0] checksum;
        logic [16:0] live_count;
    } result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    entity_slot_property_store_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the store contents.
    logic [31:0] prop_mem [SLOTS*PROPS];
    logic        in_use   [SLOTS];
    logic [31:0] born_at  [SLOTS];
    int          free_lifo[$];
    int          live_slots[$];
    int          fresh_ptr;
    logic [31:0] done_frame;
    int          n_live;

    result_t     pending_q[$];
    int          n_fail;
    int          burst_left;
    int          wdog;

    // Predicted outcome of one command; updates the shadow state.
    function automatic result_t apply_cmd(essp_pkg::cmd_t c);
        result_t r;
        int      s;
        logic [31:0] acc;
        r = '{status: essp_pkg::ST_OK, entity_id: '0, read_value: '0, frame_ok: 1'b0,
              checksum: '0, live_count: '0};
        case (c.operation)
            essp_pkg::OP_ALLOC: begin
                s = -1;
                if (free_lifo.size() > 0) s = free_lifo.pop_back();
                else if (fresh_ptr < SLOTS) begin
                    s = fresh_ptr;
                    fresh_ptr++;
                end
                if (s < 0) r.status = essp_pkg::ST_LIMIT;
                else begin
                    if (!in_use[s]) n_live++;
                    in_use[s] = 1'b1;
                    born_at[s] = done_frame;
                    for (int p = 0; p < PROPS; p++) prop_mem[s*PROPS+p] = '0;
                    live_slots.push_back(s);
                    r.entity_id = 16'(s);
                end
            end
            essp_pkg::OP_FREE: begin
                if (c.entity >= SLOTS || !in_use[c.entity]) r.status = essp_pkg::ST_INVAL;
                else begin
                    in_use[c.entity] = 1'b0;
                    n_live--;
                    free_lifo.push_back(c.entity);
                    foreach (live_slots[i])
                        if (live_slots[i] == c.entity) begin
                            live_slots.delete(i);
                            break;
                        end
                end
            end
            essp_pkg::OP_READ, essp_pkg::OP_WRITE: begin
                if (c.entity >= SLOTS || !in_use[c.entity] || c.property_req >= PROPS)
                    r.status = essp_pkg::ST_INVAL;
                else if (c.operation == essp_pkg::OP_READ)
                    r.read_value = prop_mem[c.entity*PROPS+c.property_req];
                else
                    prop_mem[c.entity*PROPS+c.property_req] = c.value;
            end
            essp_pkg::OP_SETF: done_frame = c.frame;
            essp_pkg::OP_CHKF: begin
                if (c.entity >= SLOTS || !in_use[c.entity]) r.status = essp_pkg::ST_INVAL;
                else r.frame_ok = $signed(born_at[c.entity]) <= $signed(c.frame);
            end
            essp_pkg::OP_CSUM: begin
                acc = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!in_use[i]) continue;
                    for (int p = 0; p < PROPS; p++) begin
                        acc ^= prop_mem[i*PROPS+p];
                        acc = {acc[30:0], acc[essp_pkg::ROT_TOP]};
                    end
                    acc ^= 32'(i);
                end
                r.checksum = acc ^ done_frame;
            end
            default: ;  // dirty marks are not visible on the result channel
        endcase
        r.live_count = 17'(n_live);
        return r;
    endfunction

    // One transfer on the input channel, with bursty gaps.
    task automatic send_cmd(essp_pkg::cmd_t c);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tdata  = {5'b0, c.frame, c.value, c.property_req, c.entity, c.operation};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_q.push_back(apply_cmd(c));
    endtask

    task automatic send_op(logic [2:0] op, logic [15:0] ent = '0, logic [15:0] prop = '0,
                           logic [31:0] val = '0, logic [31:0] frm = '0);
        essp_pkg::cmd_t c;
        c.operation = op;
        c.entity = ent;
        c.property_req = prop;
        c.value = val;
        c.frame = frm;
        send_cmd(c);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: stalls in stretches, with quiet stretches where it always takes.
    int stall_mode;
    int mode_left;
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(5, 60);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = ($urandom_range(0, 4) == 0);
            default: m_tready = ($urandom_range(0, 4) != 0);
        endcase
    end

    // Result checker: compare each transfer against the oldest prediction.
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                if (m_tdata[1:0] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tdata[1:0]);
                    n_fail++;
                end
                if (m_tdata[17:2] !== e.entity_id) begin
                    $error("entity_id exp %0d got %0d", e.entity_id, m_tdata[17:2]);
                    n_fail++;
                end
                if (m_tdata[49:18] !== e.read_value) begin
                    $error("read_value exp %h got %h", e.read_value, m_tdata[49:18]);
                    n_fail++;
                end
                if (m_tdata[50] !== e.frame_ok) begin
                    $error("frame_ok exp %0d got %0d", e.frame_ok, m_tdata[50]);
                    n_fail++;
                end
                if (m_tdata[82:51] !== e.checksum) begin
                    $error("checksum exp %h got %h", e.checksum, m_tdata[82:51]);
                    n_fail++;
                end
                if (m_tdata[99:83] !== e.live_count) begin
                    $error("live_count exp %0d got %0d", e.live_count, m_tdata[99:83]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed corners: extremes, every operation, each special case.
    task automatic test_directed();
        send_op(essp_pkg::OP_CSUM);                               // empty store
        send_op(essp_pkg::OP_READ, 16'd0, 16'd0);                 // invalid entity
        send_op(essp_pkg::OP_FREE, 16'hFFFF);                     // entity out of range
        send_op(essp_pkg::OP_CHKF, 16'd3, 16'd0, 32'd0, 32'd0);   // check of an unused slot
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_WRITE, 16'd1, 16'd0, 32'h8000_0000);
        send_op(essp_pkg::OP_WRITE, 16'd1, 16'd15, 32'h7FFF_FFFF);
        send_op(essp_pkg::OP_WRITE, 16'd1, 16'd15, 32'h7FFF_FFFF); // same value again
        send_op(essp_pkg::OP_WRITE, 16'd1, 16'd16, 32'hFFFF_FFFF); // property out of range
        send_op(essp_pkg::OP_READ, 16'd1, 16'hFFFF);
        send_op(essp_pkg::OP_READ, 16'd1, 16'd15);
        send_op(essp_pkg::OP_READ, 16'd1, 16'd0);
        send_op(essp_pkg::OP_CSUM);
        send_op(essp_pkg::OP_FREE, 16'd1);
        send_op(essp_pkg::OP_FREE, 16'd1);                        // double free
        send_op(essp_pkg::OP_WRITE, 16'd1, 16'd2, 32'd5);         // write to a freed slot
        send_op(essp_pkg::OP_SETF, 16'd0, 16'd0, 32'd0, 32'h8000_0000);
        send_op(essp_pkg::OP_ALLOC);                              // pops the free stack
        send_op(essp_pkg::OP_CHKF, 16'd1, 16'd0, 32'd0, 32'h8000_0000);
        send_op(essp_pkg::OP_CHKF, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_op(essp_pkg::OP_SETF, 16'd0, 16'd0, 32'd0, 32'h7FFF_FFFF);
        send_op(essp_pkg::OP_CLRD);
        send_op(essp_pkg::OP_CSUM);
    endtask

    function automatic logic [15:0] pick_entity();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && live_slots.size() > 0)
            return 16'(live_slots[$urandom_range(0, live_slots.size()-1)]);
        if (k < 9) return 16'($urandom_range(0, SLOTS-1));
        return 16'($urandom());
    endfunction

    // Mostly well-formed traffic on a small set of live slots.
    task automatic test_random(int n_items);
        essp_pkg::cmd_t c;
        int   w;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items/2) drain_results();     // hold off until all results are back
            w = $urandom_range(0, 99);
            c.operation = (w < 15) ? (n_live > 48 ? essp_pkg::OP_FREE : essp_pkg::OP_ALLOC) :
                          (w < 25) ? essp_pkg::OP_FREE  :
                          (w < 45) ? essp_pkg::OP_READ  :
                          (w < 75) ? essp_pkg::OP_WRITE :
                          (w < 80) ? essp_pkg::OP_SETF  :
                          (w < 92) ? essp_pkg::OP_CHKF  :
                          (w < 94) ? essp_pkg::OP_CSUM  : essp_pkg::OP_CLRD;
            c.entity = pick_entity();
            c.property_req = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                         : 16'($urandom_range(0, PROPS-1));
            c.value = $urandom();
            if ($urandom_range(0, 7) == 0 && c.entity < SLOTS && c.property_req < PROPS)
                c.value = prop_mem[c.entity*PROPS+c.property_req];   // no-change write
            c.frame = $urandom();
            if ($urandom_range(0, 1) && c.entity < SLOTS)
                c.frame = born_at[c.entity] + $urandom_range(0, 2) - 1;
            send_cmd(c);
        end
    endtask

    // Use up every slot, hit the slot limit, then recycle a few.
    task automatic test_slot_limit();
        while (fresh_ptr < SLOTS || free_lifo.size() > 0) send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_CSUM);
        send_op(essp_pkg::OP_FREE, 16'(SLOTS-1));
        send_op(essp_pkg::OP_FREE, 16'd0);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_ALLOC);
        send_op(essp_pkg::OP_CSUM);
    endtask

    initial begin
        n_fail = 0;
        burst_left = 0;
        wdog = 0;
        stall_mode = 0;
        mode_left = 0;
        fresh_ptr = 0;
        done_frame = '0;
        n_live = 0;
        foreach (in_use[i]) begin
            in_use[i] = 1'b0;
            born_at[i] = '0;
        end
        foreach (prop_mem[i]) prop_mem[i] = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(850);
        test_slot_limit();

        drain_results();
        repeat (200) @(posedge aclk);
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
